// ===== src/i2c_register_access_master_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define I2CRAM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cram: %m failed");

// Next-cycle implication, checked out of reset.
`define I2CRAM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cram: %m failed");

`endif

// ===== src/i2cram_pkg.sv =====
package i2cram_pkg;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_BIT_LOW   = 4'd3,
    PH_BIT_HIGH  = 4'd4,
    PH_ACK_LOW   = 4'd5,
    PH_ACK_WAIT  = 4'd6,
    PH_RS_LOW    = 4'd7,
    PH_RD_LOW    = 4'd8,
    PH_RD_HIGH   = 4'd9,
    PH_NACK_LOW  = 4'd10,
    PH_NACK_HIGH = 4'd11,
    PH_STOP_A    = 4'd12,
    PH_STOP_B    = 4'd13,
    PH_STOP_C    = 4'd14
  } phase_e;

  // register indexes
  localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] CFG_START_HOLD = 2'd1;
  localparam logic [1:0] CFG_HALF_BIT   = 2'd2;
  localparam logic [1:0] CFG_ACK_TMO    = 2'd3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // register reset values
  localparam logic [7:0] DEV_ADDR_RST   = 8'd0;
  localparam logic [7:0] START_HOLD_RST = 8'd4;
  localparam logic [7:0] HALF_BIT_RST   = 8'd2;
  localparam logic [9:0] ACK_TMO_RST    = 10'd250;

  localparam logic [1:0] BYTE_DEV  = 2'd0;
  localparam logic [1:0] BYTE_REG  = 2'd1;
  localparam logic [1:0] BYTE_LAST = 2'd2;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] start_hold;
    logic [7:0] half_bit;
    logic [9:0] ack_tmo;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic       scl;
    logic       pull;
    logic       busy;
    logic       done;
    logic [7:0] rd_data;
    logic       ack_error;
  } res_t;

endpackage

// ===== src/i2c_register_access_master.sv =====
// The result of an accepted input transfer is registered in the output register in the cycle after it is taken.
// Throughput: one tick per cycle unless stalled; the sequencer state registers advance once per transfer.
// A new tick is taken whenever the output register is empty or drains in the same cycle.
// Reset (rst_ni low, asynchronous): bus idle, output register empty, config registers
// at device address 0, hold 4, half bit 2, ACK timeout 250.
`include "i2c_register_access_master_macros.svh"

module i2c_register_access_master (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [i2cram_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cram_pkg::CfgDataW-1:0] cfg_wdata_i,
  // tick input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_request_i,
  input  logic                           op_i,
  input  logic [7:0]                     reg_addr_i,
  input  logic [7:0]                     wr_data_i,
  input  logic                           sda_in_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           scl_level_o,
  output logic                           sda_pull_low_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [7:0]                     rd_data_o,
  output logic                           ack_error_o
);
  import i2cram_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic out_valid_q, out_valid_d;
  logic in_take;

  // Register file: the user is to write it only while the bus is idle; the block itself does nothing to enforce this.
  i2cram_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Bus sequencer: one FSM step per transfer, result computed combinationally.
  i2cram_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_take),
    .cfg_i           (cfg),
    .start_request_i (start_request_i),
    .op_i            (op_i),
    .reg_addr_i      (reg_addr_i),
    .wr_data_i       (wr_data_i),
    .sda_in_i        (sda_in_i),
    .res_o           (res)
  );

  // Stall input only when the output register holds a result that is not leaving.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = res_q.scl;
  assign sda_pull_low_o = res_q.pull;
  assign busy_res_o     = res_q.busy;
  assign done_res_o     = res_q.done;
  assign rd_data_o      = res_q.rd_data;
  assign ack_error_o    = res_q.ack_error;

  // every taken tick shows up as a result on the next cycle
  `I2CRAM_ASSERT_NXT(a_take_gives_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)
  // a finishing tick is always part of a transaction
  `I2CRAM_ASSERT_IMP(a_done_in_busy, clk_i, rst_ni, out_valid_o && done_res_o, busy_res_o)
  // SCL is only driven low inside a transaction
  `I2CRAM_ASSERT_IMP(a_scl_low_busy, clk_i, rst_ni, out_valid_o && !scl_level_o, busy_res_o)

endmodule

// ===== src/i2cram_cfg.sv =====
module i2cram_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cram_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cram_pkg::CfgDataW-1:0] cfg_wdata_i,
  output i2cram_pkg::cfg_t               cfg_o
);
  import i2cram_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEV_ADDR:   cfg_d.dev_addr   = cfg_wdata_i[7:0];
        CFG_START_HOLD: cfg_d.start_hold = cfg_wdata_i[7:0];
        CFG_HALF_BIT:   cfg_d.half_bit   = cfg_wdata_i[7:0];
        CFG_ACK_TMO:    cfg_d.ack_tmo    = cfg_wdata_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= DEV_ADDR_RST;
      cfg_q.start_hold <= START_HOLD_RST;
      cfg_q.half_bit   <= HALF_BIT_RST;
      cfg_q.ack_tmo    <= ACK_TMO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/i2cram_seq.sv =====
module i2cram_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cram_pkg::cfg_t  cfg_i,
  input  logic              start_request_i,
  input  logic              op_i,
  input  logic [7:0]        reg_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              sda_in_i,
  output i2cram_pkg::res_t  res_o
);
  import i2cram_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] tick_q, tick_d;
  logic [2:0] bit_q, bit_d;
  logic [1:0] byte_q, byte_d;
  logic [7:0] shift_q, shift_d;
  logic [9:0] wait_q, wait_d;
  logic       op_q, op_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] data_q, data_d;
  logic [7:0] rbyte_q, rbyte_d;
  logic       err_q, err_d;

  logic [7:0] dur, dur_eff;
  logic       over;
  logic [7:0] tick_adv;
  logic       scl, pull;
  logic [7:0] rd_shift;

  // byte to send next, chosen by the byte counter
  function automatic logic [7:0] next_byte(input logic [1:0] bidx, input logic rd,
                                           input logic [7:0] dev, input logic [7:0] ra,
                                           input logic [7:0] wd);
    logic [7:0] b;
    if (bidx == BYTE_DEV)      b = dev;
    else if (bidx == BYTE_REG) b = ra;
    else if (rd)               b = dev + 8'd1;
    else                       b = wd;
    return b;
  endfunction

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    op_d    = op_q;
    reg_d   = reg_q;
    data_d  = data_q;
    rbyte_d = rbyte_q;
    err_d   = err_q;

    // start/stop phases time off the hold register, the other timed phases off half_bit
    if (phase_q == PH_START_A || phase_q == PH_START_B || phase_q == PH_STOP_A ||
        phase_q == PH_STOP_B || phase_q == PH_STOP_C) begin
      dur = cfg_i.start_hold;
    end else begin
      dur = cfg_i.half_bit;
    end
    dur_eff  = (dur == 8'd0) ? 8'd1 : dur;
    over     = ({1'b0, tick_q} + 9'd1) >= {1'b0, dur_eff};
    tick_adv = over ? 8'd0 : tick_q + 8'd1;
    rd_shift = (tick_q == 8'd0) ? {shift_q[6:0], sda_in_i} : shift_q;

    scl  = 1'b1;
    pull = 1'b0;
    case (phase_q)
      PH_START_B:  pull = 1'b1;
      PH_BIT_LOW:  begin
        scl  = 1'b0;
        pull = ~shift_q[7];
      end
      PH_BIT_HIGH: pull = ~shift_q[7];
      PH_ACK_LOW, PH_RS_LOW, PH_RD_LOW, PH_NACK_LOW: scl = 1'b0;
      PH_STOP_A:   begin
        scl  = 1'b0;
        pull = 1'b1;
      end
      PH_STOP_B:   pull = 1'b1;
      default:     scl = 1'b1;
    endcase

    res_o.scl  = scl;
    res_o.pull = pull;
    res_o.busy = (phase_q != PH_IDLE);
    res_o.done = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (start_request_i) begin
          op_d    = op_i;
          reg_d   = reg_addr_i;
          data_d  = wr_data_i;
          err_d   = 1'b0;
          byte_d  = BYTE_DEV;
          tick_d  = 8'd0;
          phase_d = PH_START_A;
        end
      end
      PH_START_A: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_START_B;
      end
      PH_START_B: begin
        tick_d = tick_adv;
        if (over) begin
          shift_d = next_byte(byte_q, op_q, cfg_i.dev_addr, reg_q, data_q);
          bit_d   = 3'd0;
          phase_d = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        tick_d = tick_adv;
        if (over) begin
          if (bit_q == 3'd7) begin
            phase_d = PH_ACK_LOW;
          end else begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 3'd1;
            phase_d = PH_BIT_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        tick_d = tick_adv;
        if (over) begin
          wait_d  = 10'd0;
          phase_d = PH_ACK_WAIT;
        end
      end
      PH_ACK_WAIT: begin
        if (!sda_in_i) begin
          tick_d = 8'd0;
          if (byte_q == BYTE_DEV) begin
            byte_d  = BYTE_REG;
            shift_d = next_byte(BYTE_REG, op_q, cfg_i.dev_addr, reg_q, data_q);
            bit_d   = 3'd0;
            phase_d = PH_BIT_LOW;
          end else if (byte_q == BYTE_REG) begin
            byte_d = BYTE_LAST;
            if (op_q) begin
              phase_d = PH_RS_LOW;
            end else begin
              shift_d = next_byte(BYTE_LAST, op_q, cfg_i.dev_addr, reg_q, data_q);
              bit_d   = 3'd0;
              phase_d = PH_BIT_LOW;
            end
          end else if (op_q) begin
            bit_d   = 3'd0;
            shift_d = 8'd0;
            phase_d = PH_RD_LOW;
          end else begin
            phase_d = PH_STOP_A;
          end
        end else if (wait_q >= cfg_i.ack_tmo) begin
          // timeout: abort through STOP
          err_d   = 1'b1;
          tick_d  = 8'd0;
          phase_d = PH_STOP_A;
        end else begin
          wait_d = wait_q + 10'd1;
        end
      end
      PH_RS_LOW: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_START_A;
      end
      PH_RD_LOW: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        // sample on the first tick of the high phase
        shift_d = rd_shift;
        tick_d  = tick_adv;
        if (over) begin
          if (bit_q == 3'd7) begin
            rbyte_d = rd_shift;
            phase_d = PH_NACK_LOW;
          end else begin
            bit_d   = bit_q + 3'd1;
            phase_d = PH_RD_LOW;
          end
        end
      end
      PH_NACK_LOW: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_NACK_HIGH;
      end
      PH_NACK_HIGH: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_STOP_A;
      end
      PH_STOP_A: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_STOP_B;
      end
      PH_STOP_B: begin
        tick_d = tick_adv;
        if (over) phase_d = PH_STOP_C;
      end
      PH_STOP_C: begin
        tick_d = tick_adv;
        if (over) begin
          phase_d    = PH_IDLE;
          res_o.done = 1'b1;
        end
      end
      default: begin
        tick_d  = 8'd0;
        phase_d = PH_IDLE;
      end
    endcase

    res_o.rd_data   = rbyte_d;
    res_o.ack_error = err_d;
  end

  // state advances one tick per transfer taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 8'd0;
      bit_q   <= 3'd0;
      byte_q  <= BYTE_DEV;
      shift_q <= 8'd0;
      wait_q  <= 10'd0;
      op_q    <= 1'b0;
      reg_q   <= 8'd0;
      data_q  <= 8'd0;
      rbyte_q <= 8'd0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      op_q    <= op_d;
      reg_q   <= reg_d;
      data_q  <= data_d;
      rbyte_q <= rbyte_d;
      err_q   <= err_d;
    end
  end

endmodule
